@@ hw/rtl/rfp_pkg.sv @@
`default_nettype none

package rfp_pkg;

    // target framebuffer line pitch in pixels
    localparam int unsigned LINE_PITCH = 4096;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_ROWS     = 3'd0;
    localparam logic [2:0] CFG_CHUNKS_PER_ROW = 3'd1;
    localparam logic [2:0] CFG_CHUNK_PIXELS   = 3'd2;
    localparam logic [2:0] CFG_TOP_ROW        = 3'd3;
    localparam logic [2:0] CFG_LEFT_COL       = 3'd4;

    // configuration reset values and limits
    localparam logic [12:0] FRAME_ROWS_RST     = 13'd720;
    localparam logic [6:0]  CHUNKS_PER_ROW_RST = 7'd5;
    localparam logic [10:0] CHUNK_PIXELS_RST   = 11'd256;
    localparam logic [12:0] FRAME_ROWS_MAX     = 13'd4096;
    localparam logic [6:0]  CHUNKS_PER_ROW_MAX = 7'd64;
    localparam logic [10:0] CHUNK_PIXELS_MAX   = 11'd1024;

    // header marker bytes
    localparam logic [7:0] SYNC_BYTE_0 = 8'h55;
    localparam logic [7:0] SYNC_BYTE_1 = 8'haa;

    // position of a byte within one item's packet bytes
    localparam logic [3:0] BYTE_LEN_LO = 4'd0;
    localparam logic [3:0] BYTE_LEN_HI = 4'd1;
    localparam logic [3:0] BYTE_SYNC_0 = 4'd2;
    localparam logic [3:0] BYTE_SYNC_1 = 4'd3;
    localparam logic [3:0] BYTE_ADDR_0 = 4'd4;
    localparam logic [3:0] BYTE_ADDR_1 = 4'd5;
    localparam logic [3:0] BYTE_ADDR_2 = 4'd6;
    localparam logic [3:0] BYTE_ADDR_3 = 4'd7;
    localparam logic [3:0] BYTE_PIX_LO = 4'd8;
    localparam logic [3:0] BYTE_PIX_HI = 4'd9;

    // one accepted pixel with everything needed to emit its bytes
    typedef struct packed {
        logic [15:0] pix;
        logic        hdr;
        logic [10:0] len;
        logic [31:0] addr;
        logic        end_frame;
    } t_item;

    // frame position counters
    typedef struct packed {
        logic [11:0] row;
        logic [5:0]  chunk;
        logic [9:0]  pixel;
    } t_cnt;

endpackage

`default_nettype wire

@@ hw/rtl/rfp_item_calc.sv @@
`default_nettype none

module rfp_item_calc (
    input  wire logic [7:0]    i_blue,
    input  wire logic [7:0]    i_green,
    input  wire logic [7:0]    i_red,
    input  wire logic [12:0]   i_frame_rows,
    input  wire logic [6:0]    i_chunks_per_row,
    input  wire logic [10:0]   i_chunk_pixels,
    input  wire logic [11:0]   i_top_row,
    input  wire logic [11:0]   i_left_col,
    input  wire rfp_pkg::t_cnt i_cnt,
    output rfp_pkg::t_item     o_item,
    output rfp_pkg::t_cnt      o_cnt_next
);

    logic [12:0] rows;
    logic [6:0]  cpr;
    logic [10:0] cp;
    logic        end_chunk;
    logic        end_row;
    logic        end_frame;
    logic [31:0] row_term;
    logic [16:0] col_off;

    // clamp the geometry registers into their legal ranges
    always_comb begin
        rows = i_frame_rows;
        if (i_frame_rows == 13'd0) begin
            rows = 13'd1;
        end else if (i_frame_rows > rfp_pkg::FRAME_ROWS_MAX) begin
            rows = rfp_pkg::FRAME_ROWS_MAX;
        end
        cpr = i_chunks_per_row;
        if (i_chunks_per_row == 7'd0) begin
            cpr = 7'd1;
        end else if (i_chunks_per_row > rfp_pkg::CHUNKS_PER_ROW_MAX) begin
            cpr = rfp_pkg::CHUNKS_PER_ROW_MAX;
        end
        cp = i_chunk_pixels;
        if (i_chunk_pixels == 11'd0) begin
            cp = 11'd1;
        end else if (i_chunk_pixels > rfp_pkg::CHUNK_PIXELS_MAX) begin
            cp = rfp_pkg::CHUNK_PIXELS_MAX;
        end
    end

    // end of chunk, row and frame
    assign end_chunk = ({1'b0, i_cnt.pixel} + 11'd1) >= cp;
    assign end_row   = end_chunk && (({1'b0, i_cnt.chunk} + 7'd1) >= cpr);
    assign end_frame = end_row && (({1'b0, i_cnt.row} + 13'd1) >= rows);

    // flipped target address, wrapping at 32 bits
    assign row_term = 32'(rows) - 32'd1 - 32'(i_cnt.row) + 32'(i_top_row);
    assign col_off  = 17'(i_cnt.chunk) * 17'(cp);

    always_comb begin
        o_item.pix       = {i_red[7:3], i_green[7:2], i_blue[7:3]};
        o_item.hdr       = (i_cnt.pixel == 10'd0);
        o_item.len       = cp;
        o_item.addr      = 32'(row_term * 32'(rfp_pkg::LINE_PITCH)) + 32'(i_left_col)
                           + 32'(col_off);
        o_item.end_frame = end_frame;
    end

    // counter advance with wrap at chunk, row and frame ends
    always_comb begin
        o_cnt_next = i_cnt;
        if (!end_chunk) begin
            o_cnt_next.pixel = i_cnt.pixel + 10'd1;
        end else begin
            o_cnt_next.pixel = 10'd0;
            if (!end_row) begin
                o_cnt_next.chunk = i_cnt.chunk + 6'd1;
            end else begin
                o_cnt_next.chunk = 6'd0;
                if (!end_frame) begin
                    o_cnt_next.row = i_cnt.row + 12'd1;
                end else begin
                    o_cnt_next.row = 12'd0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rfp_byte_ser.sv @@
`default_nettype none

module rfp_byte_ser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire rfp_pkg::t_item i_item,
    output logic                o_busy,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_data_byte,
    output logic                o_packet_start,
    output logic                o_frame_end,
    output logic                o_last_of_item
);

    logic           r_item_valid;
    rfp_pkg::t_item r_item;
    logic [3:0]     r_idx;
    logic           r_o_valid;
    logic [7:0]     r_o_byte;
    logic           r_o_start;
    logic           r_o_fend;
    logic           r_o_last;

    logic           adv;
    logic           last_byte;
    logic [7:0]     n_byte;
    logic           n_start;
    logic           n_fend;
    logic           n_last;

    // a byte moves into the output register when it is empty or being taken
    assign adv       = r_item_valid && (!r_o_valid || !i_out_stall);
    assign last_byte = (r_idx == rfp_pkg::BYTE_PIX_HI);
    assign o_busy    = r_item_valid && !(adv && last_byte);

    // byte select by position in the packet
    always_comb begin
        n_byte  = 8'h00;
        n_start = 1'b0;
        n_fend  = 1'b0;
        n_last  = 1'b0;
        case (r_idx)
            rfp_pkg::BYTE_LEN_LO: begin
                n_byte  = r_item.len[7:0];
                n_start = 1'b1;
            end
            rfp_pkg::BYTE_LEN_HI: n_byte = {5'd0, r_item.len[10:8]};
            rfp_pkg::BYTE_SYNC_0: n_byte = rfp_pkg::SYNC_BYTE_0;
            rfp_pkg::BYTE_SYNC_1: n_byte = rfp_pkg::SYNC_BYTE_1;
            rfp_pkg::BYTE_ADDR_0: n_byte = r_item.addr[7:0];
            rfp_pkg::BYTE_ADDR_1: n_byte = r_item.addr[15:8];
            rfp_pkg::BYTE_ADDR_2: n_byte = r_item.addr[23:16];
            rfp_pkg::BYTE_ADDR_3: n_byte = r_item.addr[31:24];
            rfp_pkg::BYTE_PIX_LO: n_byte = r_item.pix[7:0];
            rfp_pkg::BYTE_PIX_HI: begin
                n_byte = r_item.pix[15:8];
                n_fend = r_item.end_frame;
                n_last = 1'b1;
            end
            default: n_byte = 8'h00;
        endcase
    end

    // item register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_idx        <= rfp_pkg::BYTE_LEN_LO;
        end else begin
            if (i_load) begin
                r_item_valid <= 1'b1;
                r_idx        <= i_item.hdr ? rfp_pkg::BYTE_LEN_LO : rfp_pkg::BYTE_PIX_LO;
            end else if (adv) begin
                if (last_byte) begin
                    r_item_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_byte  <= n_byte;
            r_o_start <= n_start;
            r_o_fend  <= n_fend;
            r_o_last  <= n_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_data_byte    = r_o_byte;
    assign o_packet_start = r_o_start;
    assign o_frame_end    = r_o_fend;
    assign o_last_of_item = r_o_last;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_valid |-> (r_idx <= rfp_pkg::BYTE_PIX_HI))
        else $error("byte position past end of packet");

    a_no_hdr_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && !i_item.hdr) |=> (r_idx == rfp_pkg::BYTE_PIX_LO))
        else $error("item without header not started at pixel byte");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_start && r_o_last))
        else $error("packet start on last byte of item");

    a_fend_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_fend) |-> r_o_last)
        else $error("frame end not on last byte of item");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_item_valid || (adv && last_byte)))
        else $error("item loaded over unfinished item");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rgb565_frame_packetizer_top.sv @@
// channel   signals                               direction
// ------    ------------------------------------  ---------
// pixel     i_in_valid o_in_stall i_blue/green/red  in
// bytes     o_out_valid i_out_stall o_data_byte ... out
// config    i_cfg_we i_cfg_idx i_cfg_data          in
//
// a pixel leaves as 2 byte transfers, or 10 when it opens a chunk; the byte-wide
// output register sets the sustained pixel rate
// the first byte passes through the item register and then the output register
// the next pixel is taken while the last byte of the previous one still waits
// synchronous reset clears counters and handshakes and restores config defaults
`default_nettype none

module rgb565_frame_packetizer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_blue,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_red,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_data_byte,
    output logic             o_packet_start,
    output logic             o_frame_end,
    output logic             o_last_of_item
);

    logic [12:0]    r_frame_rows;
    logic [6:0]     r_chunks_per_row;
    logic [10:0]    r_chunk_pixels;
    logic [11:0]    r_top_row;
    logic [11:0]    r_left_col;
    rfp_pkg::t_cnt  r_cnt;
    rfp_pkg::t_cnt  n_cnt;
    rfp_pkg::t_item item;
    logic           busy;
    logic           in_xfer;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows     <= rfp_pkg::FRAME_ROWS_RST;
            r_chunks_per_row <= rfp_pkg::CHUNKS_PER_ROW_RST;
            r_chunk_pixels   <= rfp_pkg::CHUNK_PIXELS_RST;
            r_top_row        <= 12'd0;
            r_left_col       <= 12'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rfp_pkg::CFG_FRAME_ROWS:     r_frame_rows     <= i_cfg_data;
                rfp_pkg::CFG_CHUNKS_PER_ROW: r_chunks_per_row <= i_cfg_data[6:0];
                rfp_pkg::CFG_CHUNK_PIXELS:   r_chunk_pixels   <= i_cfg_data[10:0];
                rfp_pkg::CFG_TOP_ROW:        r_top_row        <= i_cfg_data[11:0];
                rfp_pkg::CFG_LEFT_COL:       r_left_col       <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = busy;
    assign in_xfer    = i_in_valid && !busy;

    // header fields, pixel conversion and counter advance
    rfp_item_calc u_calc (
        .i_blue           (i_blue),
        .i_green          (i_green),
        .i_red            (i_red),
        .i_frame_rows     (r_frame_rows),
        .i_chunks_per_row (r_chunks_per_row),
        .i_chunk_pixels   (r_chunk_pixels),
        .i_top_row        (r_top_row),
        .i_left_col       (r_left_col),
        .i_cnt            (r_cnt),
        .o_item           (item),
        .o_cnt_next       (n_cnt)
    );

    // frame position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer) begin
            r_cnt <= n_cnt;
        end
    end

    // byte sequencer and output register
    rfp_byte_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_xfer),
        .i_item         (item),
        .o_busy         (busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_byte    (o_data_byte),
        .o_packet_start (o_packet_start),
        .o_frame_end    (o_frame_end),
        .o_last_of_item (o_last_of_item)
    );

endmodule

`default_nettype wire

@@ verif/tb_rgb565_frame_packetizer_top.sv @@
`default_nettype none

module tb_rgb565_frame_packetizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // one byte of the packet stream as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       pkt_start;
        logic       frm_end;
        logic       pix_last;
    } t_stream_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = rfp_pkg::CFG_FRAME_ROWS;
    logic [12:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_blue = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_red = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_packet_start;
    logic        o_frame_end;
    logic        o_last_of_item;

    // shadow of the configuration and frame position
    logic [12:0] cfg_rows;
    logic [6:0]  cfg_chunks;
    logic [10:0] cfg_chunk_pix;
    logic [11:0] cfg_top;
    logic [11:0] cfg_left;
    logic [11:0] row_pos;
    logic [5:0]  chunk_pos;
    logic [9:0]  pixel_pos;

    t_stream_byte expected_bytes[$];
    t_stream_byte head_byte;
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  holdoff_left = 0;
    bit           tx_quiet = 1'b0;
    bit           rx_quiet = 1'b0;

    rgb565_frame_packetizer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_byte    (o_data_byte),
        .o_packet_start (o_packet_start),
        .o_frame_end    (o_frame_end),
        .o_last_of_item (o_last_of_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void add_byte(logic [7:0] data, logic st, logic fe, logic last);
        t_stream_byte sb;
        sb.data      = data;
        sb.pkt_start = st;
        sb.frm_end   = fe;
        sb.pix_last  = last;
        expected_bytes.push_back(sb);
    endfunction

    // bytes caused by one pixel: optional chunk header, then rgb565 low/high
    function automatic void predict_pixel_bytes(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int unsigned rows;
        int unsigned cpr;
        int unsigned cp;
        logic [31:0] addr;
        logic [15:0] rgb;
        bit          end_chunk;
        bit          end_row;
        bit          end_frame;
        rows = clamp_cfg(32'(cfg_rows), 32'(rfp_pkg::FRAME_ROWS_MAX));
        cpr  = clamp_cfg(32'(cfg_chunks), 32'(rfp_pkg::CHUNKS_PER_ROW_MAX));
        cp   = clamp_cfg(32'(cfg_chunk_pix), 32'(rfp_pkg::CHUNK_PIXELS_MAX));
        rgb  = {r[7:3], g[7:2], b[7:3]};
        end_chunk = (32'(pixel_pos) + 1) >= cp;
        end_row   = end_chunk && ((32'(chunk_pos) + 1) >= cpr);
        end_frame = end_row && ((32'(row_pos) + 1) >= rows);
        if (pixel_pos == 0) begin
            // flipped row, wraps modulo 2^32 when a counter overran its limit
            addr = (rows - 1 - 32'(row_pos) + 32'(cfg_top)) * rfp_pkg::LINE_PITCH
                   + 32'(cfg_left) + 32'(chunk_pos) * cp;
            add_byte(8'(cp), 1'b1, 1'b0, 1'b0);
            add_byte(8'(cp >> 8), 1'b0, 1'b0, 1'b0);
            add_byte(rfp_pkg::SYNC_BYTE_0, 1'b0, 1'b0, 1'b0);
            add_byte(rfp_pkg::SYNC_BYTE_1, 1'b0, 1'b0, 1'b0);
            add_byte(addr[7:0], 1'b0, 1'b0, 1'b0);
            add_byte(addr[15:8], 1'b0, 1'b0, 1'b0);
            add_byte(addr[23:16], 1'b0, 1'b0, 1'b0);
            add_byte(addr[31:24], 1'b0, 1'b0, 1'b0);
        end
        add_byte(rgb[7:0], 1'b0, 1'b0, 1'b0);
        add_byte(rgb[15:8], 1'b0, end_frame, 1'b1);
        // advance position, wrapping at chunk, row and frame ends
        if (!end_chunk) begin
            pixel_pos = pixel_pos + 10'd1;
        end else begin
            pixel_pos = '0;
            if (!end_row) begin
                chunk_pos = chunk_pos + 6'd1;
            end else begin
                chunk_pos = '0;
                row_pos = end_frame ? '0 : row_pos + 12'd1;
            end
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // follow register writes, pixel transfers and byte transfers at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_rows      = rfp_pkg::FRAME_ROWS_RST;
            cfg_chunks    = rfp_pkg::CHUNKS_PER_ROW_RST;
            cfg_chunk_pix = rfp_pkg::CHUNK_PIXELS_RST;
            cfg_top       = '0;
            cfg_left      = '0;
            row_pos       = '0;
            chunk_pos     = '0;
            pixel_pos     = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rfp_pkg::CFG_FRAME_ROWS:     cfg_rows      = i_cfg_data;
                    rfp_pkg::CFG_CHUNKS_PER_ROW: cfg_chunks    = i_cfg_data[6:0];
                    rfp_pkg::CFG_CHUNK_PIXELS:   cfg_chunk_pix = i_cfg_data[10:0];
                    rfp_pkg::CFG_TOP_ROW:        cfg_top       = i_cfg_data[11:0];
                    rfp_pkg::CFG_LEFT_COL:       cfg_left      = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                predict_pixel_bytes(i_blue, i_green, i_red);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte transfer, expected none, got %0h",
                             $time, o_data_byte);
                    error_count++;
                end else begin
                    head_byte = expected_bytes.pop_front();
                    check_field("data_byte", 32'(head_byte.data), 32'(o_data_byte));
                    check_field("packet_start", 32'(head_byte.pkt_start),
                                32'(o_packet_start));
                    check_field("frame_end", 32'(head_byte.frm_end), 32'(o_frame_end));
                    check_field("last_of_item", 32'(head_byte.pix_last),
                                32'(o_last_of_item));
                end
            end
        end
    end

    // receiver stall: long hold-off on request, quiet stretch, else random
    always @(posedge i_clk) begin
        if (holdoff_left != 0) begin
            i_out_stall <= 1'b1;
            holdoff_left = holdoff_left - 1;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 18);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one pixel and hold it until the transfer happens
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        if (!tx_quiet && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_blue     <= b;
        i_green    <= g;
        i_red      <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random_pixels(input int unsigned count);
        repeat (count) begin
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        end
    endtask

    // stop offering and wait until every expected byte has left
    task automatic wait_bytes_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [2:0] idx, input logic [12:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // all registers are rewritten, only once the block has gone idle
    task automatic load_config(input logic [12:0] rows, input logic [6:0] cpr,
                               input logic [10:0] cp, input logic [11:0] top,
                               input logic [11:0] left);
        wait_bytes_done();
        cfg_put(rfp_pkg::CFG_FRAME_ROWS, rows);
        cfg_put(rfp_pkg::CFG_CHUNKS_PER_ROW, 13'(cpr));
        cfg_put(rfp_pkg::CFG_CHUNK_PIXELS, 13'(cp));
        cfg_put(rfp_pkg::CFG_TOP_ROW, 13'(top));
        cfg_put(rfp_pkg::CFG_LEFT_COL, 13'(left));
        i_cfg_we <= 1'b0;
    endtask

    // mostly small frames so headers and frame ends come often
    task automatic pick_random_config();
        logic [12:0] rows;
        logic [6:0]  cpr;
        logic [10:0] cp;
        logic [11:0] top;
        logic [11:0] left;
        case ($urandom_range(9))
            0:       rows = '0;
            1:       rows = 13'h1fff;
            default: rows = 13'($urandom_range(4, 1));
        endcase
        case ($urandom_range(9))
            0:       cpr = '0;
            1:       cpr = 7'h7f;
            default: cpr = 7'($urandom_range(4, 1));
        endcase
        case ($urandom_range(11))
            0:       cp = '0;
            1:       cp = 11'h7ff;
            default: cp = 11'($urandom_range(6, 1));
        endcase
        case ($urandom_range(4))
            0:       top = '0;
            1:       top = 12'hfff;
            default: top = 12'($urandom_range(4095));
        endcase
        case ($urandom_range(4))
            0:       left = '0;
            1:       left = 12'hfff;
            default: left = 12'($urandom_range(4095));
        endcase
        load_config(rows, cpr, cp, top, left);
    endtask

    // color extremes under the reset configuration
    task automatic test_pixel_extremes();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hff, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hff);
        send_pixel(8'h07, 8'h03, 8'h07);
    endtask

    // zero acts as one, oversize values saturate, header length follows
    task automatic test_register_clamp();
        load_config('0, '0, '0, '0, '0);
        send_random_pixels(3);
        load_config(13'h1fff, 7'h7f, 11'h7ff, 12'hfff, 12'hfff);
        send_random_pixels(3);
    endtask

    // counters left beyond a limit after a smaller setting is loaded mid-frame
    task automatic test_counter_overrun();
        load_config(13'd8, 7'd1, 11'd1, 12'd0, 12'd0);
        send_random_pixels(5);
        // row beyond frame_rows, address wraps below zero
        load_config(13'd1, 7'd1, 11'd1, 12'd0, 12'd0);
        send_random_pixels(1);
        load_config(13'd2, 7'd3, 11'd8, 12'd7, 12'd9);
        send_random_pixels(4);
        // pixel beyond chunk_pixels
        load_config(13'd2, 7'd3, 11'd2, 12'd7, 12'd9);
        send_random_pixels(1);
        // chunk beyond chunks_per_row
        load_config(13'd2, 7'd1, 11'd2, 12'd7, 12'd9);
        send_random_pixels(2);
    endtask

    task automatic test_random_traffic();
        repeat (10) begin
            pick_random_config();
            send_random_pixels($urandom_range(40, 20));
        end
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_burst_no_idle();
        pick_random_config();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_random_pixels(60);
        wait_bytes_done();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_holdoff();
        load_config(13'd3, 7'd2, 11'd4, 12'($urandom_range(4095)),
                    12'($urandom_range(4095)));
        holdoff_left = 150;
        tx_quiet = 1'b1;
        send_random_pixels(30);
        tx_quiet = 1'b0;
    endtask

    // sender pauses until the stream has fully drained, then resumes
    task automatic test_sender_pause();
        pick_random_config();
        send_random_pixels(12);
        wait_bytes_done();
        send_random_pixels(12);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_pixel_extremes();
        test_register_clamp();
        test_counter_overrun();
        test_random_traffic();
        test_burst_no_idle();
        test_output_holdoff();
        test_sender_pause();
        wait_bytes_done();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ rgb565_frame_packetizer_top.f @@
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_item_calc.sv
hw/rtl/rfp_byte_ser.sv
hw/rtl/rgb565_frame_packetizer_top.sv
verif/tb_rgb565_frame_packetizer_top.sv
